[rtl/core/twodo_pkg.sv]
package twodo_pkg;

   localparam logic [2:0] REG_LEFT_OFFSET   = 3'd0;
   localparam logic [2:0] REG_RIGHT_OFFSET  = 3'd1;
   localparam logic [2:0] REG_BACK_OFFSET   = 3'd2;
   localparam logic [2:0] REG_IPD           = 3'd3;
   localparam logic [2:0] REG_START_LEFT    = 3'd4;
   localparam logic [2:0] REG_START_RIGHT   = 3'd5;
   localparam logic [2:0] REG_START_HEADING = 3'd6;

   // cordic angle input, Q30 radians, wide enough for 64 * heading + 32 * delta
   localparam int ANGLE_W = 40;
   // cordic x/y width
   localparam int CS_W = 34;
   // reduced angle width inside the cordic
   localparam int RED_W = 35;
   // shared multiplier operand and product widths
   localparam int MUL_W  = 35;
   localparam int PROD_W = 70;
   // divider numerator (value * 2^24) and divisor widths
   localparam int NUM_W = 57;
   localparam int DEN_W = 33;

   localparam logic [ANGLE_W-1:0]       TWO_PI_A  = 40'd6746518852;
   localparam logic signed [RED_W-1:0]  TWO_PI_R  = 35'sd6746518852;
   localparam logic signed [RED_W-1:0]  PI_R      = 35'sd3373259426;
   localparam logic signed [RED_W-1:0]  HALF_PI_R = 35'sd1686629713;
   localparam logic signed [CS_W-1:0]   CORDIC_GAIN = 34'sd652032874;

   // clip to 32-bit signed, msb of the result flags a clip
   function automatic logic [32:0] sat32(input logic signed [71:0] v);
      logic [32:0] r;
      if (v > 72'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -72'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   function automatic logic signed [RED_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [RED_W-1:0] r;
      case (i)
         5'd0:  r = 35'sd843314857;
         5'd1:  r = 35'sd497837829;
         5'd2:  r = 35'sd263043837;
         5'd3:  r = 35'sd133525159;
         5'd4:  r = 35'sd67021687;
         5'd5:  r = 35'sd33543516;
         5'd6:  r = 35'sd16775851;
         5'd7:  r = 35'sd8388437;
         5'd8:  r = 35'sd4194283;
         5'd9:  r = 35'sd2097149;
         5'd10: r = 35'sd1048576;
         5'd11: r = 35'sd524288;
         5'd12: r = 35'sd262144;
         5'd13: r = 35'sd131072;
         5'd14: r = 35'sd65536;
         5'd15: r = 35'sd32768;
         5'd16: r = 35'sd16384;
         5'd17: r = 35'sd8192;
         5'd18: r = 35'sd4096;
         5'd19: r = 35'sd2048;
         5'd20: r = 35'sd1024;
         5'd21: r = 35'sd512;
         5'd22: r = 35'sd256;
         5'd23: r = 35'sd128;
         5'd24: r = 35'sd64;
         5'd25: r = 35'sd32;
         5'd26: r = 35'sd16;
         5'd27: r = 35'sd8;
         5'd28: r = 35'sd4;
         5'd29: r = 35'sd2;
         5'd30: r = 35'sd1;
         default: r = 35'sd0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/tracking_wheel_odometry_unit.sv]
// channel  dir  handshake                 payload
// req      in   req_tvalid / req_tready   angle_left, angle_right, angle_back
// rsp      out  rsp_tvalid / rsp_tready   pos_x, pos_y, heading_out, overflow
// csr      in   csr_psel / csr_penable    seven 32-bit registers at 4*index
//
// when the heading changes, one request runs three divisions on one shared
// divider (cordic runs hidden under two of them), and when it does not, one
// division, then the mid-heading cordic; a zero wheel base skips the first.
// products go through one shared 35x35 multiplier, one per cycle.
// reset is synchronous; it loads the register defaults and clears the pose.
// req_tready is high only while idle; a finished result waits in the output
// register and only the final step stalls on it.
module tracking_wheel_odometry_unit
   import twodo_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle_left [30:0], angle_right [61:31], angle_back [92:62], zero [95:93]
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x [31:0], pos_y [63:32], heading_out [95:64], overflow [96], zero [103:97]
   output logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MR, ST_MS, ST_ML, ST_MT, ST_DIFF, ST_WQ, ST_HEAD, ST_DTH, ST_BR,
      ST_WAX, ST_AX, ST_WAY, ST_AY, ST_LX, ST_LY, ST_WM, ST_G1, ST_G2, ST_G3,
      ST_G4, ST_G5
   } state_type;

   state_type state_ff;

   logic [21:0]        left_off_ff;
   logic [21:0]        right_off_ff;
   logic [21:0]        back_off_ff;
   logic [16:0]        ipd_ff;
   logic signed [30:0] start_l_ff;
   logic signed [30:0] start_r_ff;
   logic signed [31:0] start_h_ff;

   logic signed [30:0] al_ff, ar_ff, ab_ff;
   logic signed [30:0] prev_r_ff, prev_b_ff;
   logic signed [31:0] dr_ff, ds_ff, tl_ff, ax_ff, ay_ff, lx_ff, ly_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff, head_ff, last_ff;
   logic signed [NUM_W:0]    q_ff;
   logic signed [DEN_W-1:0]  dth_ff;
   logic signed [MUL_W-1:0]  chord_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic               ovf_ff;
   logic               rsp_valid_ff;
   logic [103:0]       rsp_data_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic [32:0]        sat_p, sat_ps, sat_head, sat_ax, sat_ay, sat_x, sat_y;
   logic signed [32:0] diff;
   logic [22:0]        den;
   logic signed [PROD_W:0] gsum_x, gsum_y;
   logic signed [ANGLE_W-1:0] ang_d, ang_m;

   logic                     div_start, div_busy;
   logic signed [NUM_W-1:0]  div_num;
   logic signed [DEN_W-1:0]  div_den;
   logic signed [NUM_W:0]    div_quot;
   logic                     cor_start, cor_busy;
   logic signed [ANGLE_W-1:0] cor_angle;
   logic signed [CS_W-1:0]   cor_cos, cor_sin;

   logic       csr_we;
   logic [2:0] csr_idx;
   logic       req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   assign sat_p    = sat32(72'(prod_ff));
   assign sat_ps   = sat32(72'(prod_ff >>> 30));
   assign diff     = 33'(tl_ff) - 33'($signed(sat_p[31:0]));
   assign den      = {1'b0, left_off_ff} + {1'b0, right_off_ff};
   assign sat_head = sat32(72'(q_ff) + 72'(start_h_ff));
   assign sat_ax   = sat32(72'(q_ff) + 72'($signed({1'b0, back_off_ff})));
   assign sat_ay   = sat32(72'(q_ff) + 72'($signed({1'b0, right_off_ff})));
   assign gsum_x   = (PROD_W+1)'(acc_ff) + (PROD_W+1)'(prod_ff);
   assign gsum_y   = (PROD_W+1)'(acc_ff) - (PROD_W+1)'(prod_ff);
   assign sat_x    = sat32(72'(acc_x_ff) + 72'(gsum_x >>> 30));
   assign sat_y    = sat32(72'(acc_y_ff) + 72'(gsum_y >>> 30));
   assign ang_d    = ANGLE_W'($signed({dth_ff, 5'b0}));
   assign ang_m    = ANGLE_W'($signed({last_ff, 6'b0})) + ang_d;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MR:   begin mul_a = MUL_W'(33'(ar_ff) - 33'(prev_r_ff));
                        mul_b = $signed({18'b0, ipd_ff}); end
         ST_MS:   begin mul_a = MUL_W'(33'(ab_ff) - 33'(prev_b_ff));
                        mul_b = $signed({18'b0, ipd_ff}); end
         ST_ML:   begin mul_a = MUL_W'(33'(al_ff) - 33'(start_l_ff));
                        mul_b = $signed({18'b0, ipd_ff}); end
         ST_MT:   begin mul_a = MUL_W'(33'(ar_ff) - 33'(start_r_ff));
                        mul_b = $signed({18'b0, ipd_ff}); end
         ST_AY:   begin mul_a = MUL_W'(ax_ff); mul_b = chord_ff; end
         ST_LX:   begin mul_a = MUL_W'(ay_ff); mul_b = chord_ff; end
         ST_G1:   begin mul_a = MUL_W'(lx_ff); mul_b = MUL_W'(cor_cos); end
         ST_G2:   begin mul_a = MUL_W'(ly_ff); mul_b = MUL_W'(cor_sin); end
         ST_G3:   begin mul_a = MUL_W'(ly_ff); mul_b = MUL_W'(cor_cos); end
         ST_G4:   begin mul_a = MUL_W'(lx_ff); mul_b = MUL_W'(cor_sin); end
         ST_G5:   begin mul_a = MUL_W'(lx_ff); mul_b = MUL_W'(cor_sin); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      div_start = ((state_ff == ST_DIFF) && (den != '0)) ||
                  ((state_ff == ST_BR) && (dth_ff != '0)) ||
                  (state_ff == ST_AX);
      case (state_ff)
         ST_DIFF: begin
            div_num = $signed({diff, 24'b0});
            div_den = $signed({10'b0, den});
         end
         ST_BR: begin
            div_num = $signed({33'(ds_ff), 24'b0});
            div_den = dth_ff;
         end
         default: begin
            div_num = $signed({33'(dr_ff), 24'b0});
            div_den = dth_ff;
         end
      endcase
      cor_start = (state_ff == ST_BR) || (state_ff == ST_AX);
      cor_angle = ((state_ff == ST_BR) && (dth_ff != '0)) ? ang_d : ang_m;
   end

   twodo_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   twodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .busy    (cor_busy),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   always_comb begin
      case (csr_idx)
         REG_LEFT_OFFSET:   csr_prdata = {10'b0, left_off_ff};
         REG_RIGHT_OFFSET:  csr_prdata = {10'b0, right_off_ff};
         REG_BACK_OFFSET:   csr_prdata = {10'b0, back_off_ff};
         REG_IPD:           csr_prdata = {15'b0, ipd_ff};
         REG_START_LEFT:    csr_prdata = {1'b0, start_l_ff};
         REG_START_RIGHT:   csr_prdata = {1'b0, start_r_ff};
         REG_START_HEADING: csr_prdata = start_h_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_off_ff  <= 22'd393216;
         right_off_ff <= 22'd393216;
         back_off_ff  <= 22'd262144;
         ipd_ff       <= 17'd2287;
         start_l_ff   <= '0;
         start_r_ff   <= '0;
         start_h_ff   <= '0;
         last_ff      <= '0;
         prev_r_ff    <= '0;
         prev_b_ff    <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  al_ff    <= req_tdata[30:0];
                  ar_ff    <= req_tdata[61:31];
                  ab_ff    <= req_tdata[92:62];
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_MR;
               end
            end
            ST_MR: state_ff <= ST_MS;
            ST_MS: begin
               dr_ff    <= sat_p[31:0];
               ovf_ff   <= ovf_ff | sat_p[32];
               state_ff <= ST_ML;
            end
            ST_ML: begin
               ds_ff    <= sat_p[31:0];
               ovf_ff   <= ovf_ff | sat_p[32];
               state_ff <= ST_MT;
            end
            ST_MT: begin
               tl_ff    <= sat_p[31:0];
               ovf_ff   <= ovf_ff | sat_p[32];
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               // tr is the product in flight this cycle
               if (den == '0) begin
                  // no wheel base: heading term pinned to the rail by sign
                  if (diff == '0) begin
                     q_ff   <= '0;
                     ovf_ff <= ovf_ff | sat_p[32];
                  end else begin
                     q_ff   <= diff[32] ? -(NUM_W+1)'(64'sd2147483648)
                                        : (NUM_W+1)'(64'sd2147483647);
                     ovf_ff <= 1'b1;
                  end
                  state_ff <= ST_HEAD;
               end else begin
                  ovf_ff   <= ovf_ff | sat_p[32];
                  state_ff <= ST_WQ;
               end
            end
            ST_WQ: begin
               if (!div_busy) begin
                  q_ff     <= div_quot;
                  state_ff <= ST_HEAD;
               end
            end
            ST_HEAD: begin
               head_ff  <= sat_head[31:0];
               ovf_ff   <= ovf_ff | sat_head[32];
               state_ff <= ST_DTH;
            end
            ST_DTH: begin
               dth_ff   <= 33'(head_ff) - 33'(last_ff);
               state_ff <= ST_BR;
            end
            ST_BR: begin
               if (dth_ff == '0) begin
                  lx_ff    <= ds_ff;
                  ly_ff    <= dr_ff;
                  state_ff <= ST_WM;
               end else begin
                  state_ff <= ST_WAX;
               end
            end
            ST_WAX: begin
               if (!div_busy && !cor_busy) begin
                  q_ff     <= div_quot;
                  chord_ff <= MUL_W'(cor_sin) <<< 1;
                  state_ff <= ST_AX;
               end
            end
            ST_AX: begin
               ax_ff    <= sat_ax[31:0];
               ovf_ff   <= ovf_ff | sat_ax[32];
               state_ff <= ST_WAY;
            end
            ST_WAY: begin
               if (!div_busy && !cor_busy) begin
                  q_ff     <= div_quot;
                  state_ff <= ST_AY;
               end
            end
            ST_AY: begin
               ay_ff    <= sat_ay[31:0];
               ovf_ff   <= ovf_ff | sat_ay[32];
               state_ff <= ST_LX;
            end
            ST_LX: begin
               lx_ff    <= sat_ps[31:0];
               ovf_ff   <= ovf_ff | sat_ps[32];
               state_ff <= ST_LY;
            end
            ST_LY: begin
               ly_ff    <= sat_ps[31:0];
               ovf_ff   <= ovf_ff | sat_ps[32];
               state_ff <= ST_G1;
            end
            ST_WM: begin
               if (!cor_busy) begin
                  state_ff <= ST_G1;
               end
            end
            ST_G1: state_ff <= ST_G2;
            ST_G2: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_G3;
            end
            ST_G3: begin
               acc_x_ff <= sat_x[31:0];
               ovf_ff   <= ovf_ff | sat_x[32];
               state_ff <= ST_G4;
            end
            ST_G4: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_G5;
            end
            ST_G5: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  acc_y_ff     <= sat_y[31:0];
                  last_ff      <= head_ff;
                  prev_r_ff    <= ar_ff;
                  prev_b_ff    <= ab_ff;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'b0, ovf_ff | sat_y[32], head_ff, sat_y[31:0], acc_x_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (csr_we) begin
            case (csr_idx)
               REG_LEFT_OFFSET:   left_off_ff  <= csr_pwdata[21:0];
               REG_RIGHT_OFFSET:  right_off_ff <= csr_pwdata[21:0];
               REG_BACK_OFFSET:   back_off_ff  <= csr_pwdata[21:0];
               REG_IPD:           ipd_ff       <= csr_pwdata[16:0];
               REG_START_LEFT:    start_l_ff   <= csr_pwdata[30:0];
               REG_START_RIGHT:   start_r_ff   <= csr_pwdata[30:0];
               REG_START_HEADING: begin
                  start_h_ff <= csr_pwdata;
                  last_ff    <= csr_pwdata;
               end
               default: ;
            endcase
         end
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while a previous one is in flight");

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!div_busy && !cor_busy))
      else $error("shared unit still running while sequencer idle");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_G5))
      else $error("result raised outside the final step");

endmodule

[rtl/core/twodo_div.sv]
module twodo_div
   import twodo_pkg::*;
#(
   parameter int NW = 57,
   parameter int DW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic                 busy,
   output logic signed [NW:0]   quot
);

   localparam int CW = $clog2(NW);

   logic [DW-1:0] rem_ff;
   logic [NW-1:0] work_ff;
   logic [DW-1:0] dmag_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;

   logic [DW:0]   trial;
   logic          fits;
   logic [DW:0]   diff;

   assign trial = {rem_ff, work_ff[NW-1]};
   assign fits  = (trial >= {1'b0, dmag_ff});
   assign diff  = trial - {1'b0, dmag_ff};

   assign busy = busy_ff;
   assign quot = neg_ff ? -$signed({1'b0, work_ff}) : $signed({1'b0, work_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (!busy_ff) begin
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            work_ff <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_ff <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_ff  <= num[NW-1] ^ den[DW-1];
            cnt_ff  <= CW'(NW - 1);
         end
      end else begin
         // one restoring step per cycle, quotient bits shift in behind the dividend
         rem_ff  <= fits ? diff[DW-1:0] : trial[DW-1:0];
         work_ff <= {work_ff[NW-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

[rtl/core/twodo_cordic.sv]
module twodo_cordic
   import twodo_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ANGLE_W-1:0] angle,
   output logic                      busy,
   output logic signed [CS_W-1:0]    cos_out,
   output logic signed [CS_W-1:0]    sin_out
);

   localparam int IW = $clog2(CORDIC_STEPS);

   typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ITER} cstate_type;

   cstate_type              state_ff;
   logic [ANGLE_W-1:0]      mag_ff;
   logic                    aneg_ff;
   logic [2:0]              k_ff;
   logic signed [RED_W-1:0] r_ff;
   logic signed [CS_W-1:0]  x_ff;
   logic signed [CS_W-1:0]  y_ff;
   logic                    neg_ff;
   logic [IW-1:0]           i_ff;

   logic [ANGLE_W-1:0]      tk;
   logic signed [RED_W-1:0] r0;
   logic signed [RED_W-1:0] r1;
   logic signed [RED_W-1:0] r2;
   logic                    fneg;
   logic signed [CS_W-1:0]  nx;
   logic signed [CS_W-1:0]  ny;
   logic signed [RED_W-1:0] nr;
   logic signed [RED_W-1:0] at;

   assign busy    = (state_ff != C_IDLE);
   assign cos_out = x_ff;
   assign sin_out = y_ff;
   assign tk      = TWO_PI_A << k_ff;

   // remainder takes the sign of the angle, then wrap into +-pi and fold into +-pi/2
   always_comb begin
      r0 = aneg_ff ? -$signed(mag_ff[RED_W-1:0]) : $signed(mag_ff[RED_W-1:0]);
      r1 = r0;
      if (r0 > PI_R) begin
         r1 = r0 - TWO_PI_R;
      end
      if (r0 < -PI_R) begin
         r1 = r0 + TWO_PI_R;
      end
      r2   = r1;
      fneg = 1'b0;
      if (r1 > HALF_PI_R) begin
         r2   = r1 - PI_R;
         fneg = 1'b1;
      end else if (r1 < -HALF_PI_R) begin
         r2   = r1 + PI_R;
         fneg = 1'b1;
      end
   end

   always_comb begin
      at = atan_q30(5'(i_ff));
      if (!r_ff[RED_W-1]) begin
         nx = x_ff - (y_ff >>> i_ff);
         ny = y_ff + (x_ff >>> i_ff);
         nr = r_ff - at;
      end else begin
         nx = x_ff + (y_ff >>> i_ff);
         ny = y_ff - (x_ff >>> i_ff);
         nr = r_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         case (state_ff)
            C_IDLE: begin
               if (start) begin
                  mag_ff   <= angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
                  aneg_ff  <= angle[ANGLE_W-1];
                  k_ff     <= 3'd6;
                  state_ff <= C_RED;
               end
            end
            C_RED: begin
               if (mag_ff >= tk) begin
                  mag_ff <= mag_ff - tk;
               end
               k_ff <= k_ff - 1'b1;
               if (k_ff == 3'd0) begin
                  state_ff <= C_FOLD;
               end
            end
            C_FOLD: begin
               r_ff     <= r2;
               neg_ff   <= fneg;
               x_ff     <= CORDIC_GAIN;
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= C_ITER;
            end
            C_ITER: begin
               r_ff <= nr;
               i_ff <= i_ff + 1'b1;
               if (i_ff == IW'(CORDIC_STEPS - 1)) begin
                  x_ff     <= neg_ff ? -nx : nx;
                  y_ff     <= neg_ff ? -ny : ny;
                  state_ff <= C_IDLE;
               end else begin
                  x_ff <= nx;
                  y_ff <= ny;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

[tb/tracking_wheel_odometry_unit_tb.sv]
module tracking_wheel_odometry_unit_tb;
   import twodo_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam longint TWO_PI = 64'sd6746518852;
   localparam longint PI_V = 64'sd3373259426;
   localparam longint HALF_PI = 64'sd1686629713;
   localparam longint GAIN = 64'sd652032874;
   localparam longint ONE_Q24 = 64'sd16777216;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct packed {
      logic        ovf;
      logic [31:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tracking_wheel_odometry_unit u_top (.*);

   always #1 clock = ~clock;

   // odometry copy: registers and pose
   logic [31:0] regs [0:6];
   logic signed [30:0] prev_l, prev_r, prev_b;
   longint pose_x, pose_y, pose_head;
   pose_type pose_q [$];
   int errors = 0;
   int cycles = 0;
   bit idle_on = 1'b1;
   int stall_cnt = 0;

   const longint atan_lut [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   function automatic int pick_gap();
      if (!idle_on) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic longint clip32(input longint v, inout bit o);
      if (v > MAX32) begin o = 1'b1; return MAX32; end
      if (v < MIN32) begin o = 1'b1; return MIN32; end
      return v;
   endfunction

   function automatic void cordic(input longint a, output longint c, output longint s);
      longint r, x, y, dx, dy;
      bit neg;
      int n;
      r = a % TWO_PI;
      x = GAIN;
      y = 0;
      neg = 1'b0;
      n = 24 > 32 ? 32 : 24;
      if (r > PI_V) r -= TWO_PI;
      if (r < -PI_V) r += TWO_PI;
      if (r > HALF_PI) begin
         r -= PI_V;
         neg = 1'b1;
      end else if (r < -HALF_PI) begin
         r += PI_V;
         neg = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (r >= 0) begin
            x -= dx; y += dy; r -= atan_lut[i];
         end else begin
            x += dx; y -= dy; r += atan_lut[i];
         end
      end
      if (neg) begin x = -x; y = -y; end
      c = x;
      s = y;
   endfunction

   function automatic pose_type advance_pose(input logic signed [30:0] al, ar, ab);
      bit o;
      longint ipd, lo, ro, bo, d_r, d_s, tl, tr, diff, den, q, head, dth;
      longint lx, ly, c, s, ax, ay, chord, gx, gy;
      logic signed [30:0] sl, sr;
      pose_type p;
      o = 1'b0;
      ipd = longint'(regs[REG_IPD][16:0]);
      lo = longint'(regs[REG_LEFT_OFFSET][21:0]);
      ro = longint'(regs[REG_RIGHT_OFFSET][21:0]);
      bo = longint'(regs[REG_BACK_OFFSET][21:0]);
      sl = regs[REG_START_LEFT][30:0];
      sr = regs[REG_START_RIGHT][30:0];
      d_r = clip32((longint'(ar) - longint'(prev_r)) * ipd, o);
      d_s = clip32((longint'(ab) - longint'(prev_b)) * ipd, o);
      tl = clip32((longint'(al) - longint'(sl)) * ipd, o);
      tr = clip32((longint'(ar) - longint'(sr)) * ipd, o);
      diff = tl - tr;
      den = lo + ro;
      if (den == 0) begin
         if (diff == 0) q = 0;
         else begin
            o = 1'b1;
            q = diff > 0 ? MAX32 : MIN32;
         end
      end else begin
         q = diff * ONE_Q24 / den;
      end
      head = clip32(longint'($signed(regs[REG_START_HEADING])) + q, o);
      dth = head - pose_head;
      if (dth == 0) begin
         lx = d_s;
         ly = d_r;
      end else begin
         cordic(dth * 32, c, s);
         chord = 2 * s;
         ax = clip32(d_s * ONE_Q24 / dth + bo, o);
         ay = clip32(d_r * ONE_Q24 / dth + ro, o);
         lx = clip32((ax * chord) >>> 30, o);
         ly = clip32((ay * chord) >>> 30, o);
      end
      cordic(pose_head * 64 + dth * 32, c, s);
      gx = (lx * c + ly * s) >>> 30;
      gy = (ly * c - lx * s) >>> 30;
      pose_x = clip32(pose_x + gx, o);
      pose_y = clip32(pose_y + gy, o);
      pose_head = head;
      prev_l = al;
      prev_r = ar;
      prev_b = ab;
      p.x = pose_x[31:0];
      p.y = pose_y[31:0];
      p.heading = head[31:0];
      p.ovf = o;
      return p;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
      end
   end

   always @(posedge clock) begin
      pose_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[96:0];
         if (pose_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pose_q.pop_front();
            if (got.x !== want.x) begin
               $display("%0t: pos_x exp %h got %h", $time, want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $display("%0t: pos_y exp %h got %h", $time, want.y, got.y);
               errors++;
            end
            if (got.heading !== want.heading) begin
               $display("%0t: heading exp %h got %h", $time, want.heading, got.heading);
               errors++;
            end
            if (got.ovf !== want.ovf) begin
               $display("%0t: overflow exp %b got %b", $time, want.ovf, got.ovf);
               errors++;
            end
         end
      end
   end

   task automatic send_sample(input logic [30:0] al, ar, ab);
      int g;
      g = pick_gap();
      repeat (g + 1) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, ab, ar, al};
      do @(posedge clock); while (!req_tready);
      pose_q.push_back(advance_pose(al, ar, ab));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pose_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 5'(idx * 4);
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx < 7) begin
         case (idx)
            REG_LEFT_OFFSET, REG_RIGHT_OFFSET, REG_BACK_OFFSET:
               regs[idx] = {10'b0, val[21:0]};
            REG_IPD: regs[idx] = {15'b0, val[16:0]};
            REG_START_LEFT, REG_START_RIGHT: regs[idx] = {1'b0, val[30:0]};
            default: begin
               regs[idx] = val;
               pose_head = longint'($signed(val));
            end
         endcase
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic test_directed();
      send_sample(31'd0, 31'd0, 31'd0);
      send_sample(31'd0, 31'd0, 31'd0);
      send_sample(31'd360, 31'd360, 31'd0);
      send_sample(31'd720, 31'd400, 31'd50);
      send_sample(31'd700, 31'd800, -31'sd90);
      send_sample(31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF);
      send_sample(31'h40000000, 31'h40000000, 31'h40000000);
      send_sample(31'h3FFFFFFF, 31'h40000000, 31'h3FFFFFFF);
      send_sample(31'h40000000, 31'h3FFFFFFF, 31'h40000000);
      send_sample(31'h7FFFFFFF, 31'h0, 31'h1);
      send_sample(31'h0, 31'h7FFFFFFF, 31'h0);
      send_sample(31'h10, 31'h10, 31'h10);
      send_sample(31'h10, 31'h10, 31'h10);
      wait_idle();
      // tiny wheel base and large wheel scale
      csr_write(REG_LEFT_OFFSET, 32'h10000);
      csr_write(REG_RIGHT_OFFSET, 32'h10000);
      csr_write(REG_BACK_OFFSET, 32'h200000);
      csr_write(REG_IPD, 32'h10000);
      send_sample(31'd5, 31'd1, 31'd3);
      send_sample(31'd100, 31'd20, 31'd30);
      send_sample(-31'sd100, 31'd20, -31'sd30);
      send_sample(31'd100, 31'd100, 31'd100);
      wait_idle();
   endtask

   task automatic test_zero_wheel_base();
      csr_write(REG_LEFT_OFFSET, 32'h0);
      csr_write(REG_RIGHT_OFFSET, 32'hFFC00000);
      csr_write(REG_BACK_OFFSET, 32'h0);
      csr_write(REG_IPD, 32'h0);
      send_sample(31'd10, 31'd20, 31'd30);
      wait_idle();
      csr_write(REG_IPD, 32'h8FF);
      send_sample(31'd10, 31'd10, 31'd30);
      send_sample(31'd30, 31'd10, 31'd40);
      send_sample(31'd10, 31'd30, 31'd40);
      wait_idle();
      csr_write(7, 32'hFFFFFFFF);
      csr_write(REG_START_HEADING, 32'h7FFFFFFF);
      csr_write(REG_LEFT_OFFSET, 32'h60000);
      csr_write(REG_RIGHT_OFFSET, 32'h60000);
      send_sample(31'd10, 31'd30, 31'd40);
      wait_idle();
   endtask

   task automatic test_random_runs();
      logic [31:0] cfg [0:6];
      logic signed [30:0] al, ar, ab;
      for (int ph = 0; ph < 9; ph++) begin
         wait_idle();
         idle_on = (ph % 3) != 1;
         case (ph)
            0: cfg = '{32'h60000, 32'h60000, 32'h40000, 32'd2287, 0, 0, 0};
            1: cfg = '{32'h3FFFFF, 32'h3FFFFF, 32'h3FFFFF, 32'h1FFFF,
                       32'h3FFFFFFF, 32'h40000000, 32'h80000000};
            2: cfg = '{32'h10000, 32'h10000, 32'h0, 32'd1,
                       32'h40000000, 32'h3FFFFFFF, 32'h7FFFFFFF};
            3: cfg = '{32'h200000, 32'h200000, 32'h200000, 32'h10000, 0, 0, 0};
            default: foreach (cfg[i]) cfg[i] = $urandom;
         endcase
         if (ph >= 4 && $urandom_range(0, 1)) cfg[REG_IPD] = $urandom_range(1, 4000);
         foreach (cfg[i]) csr_write(i, cfg[i]);
         al = prev_l;
         ar = prev_r;
         ab = prev_b;
         for (int n = 0; n < 110; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  al = 31'($urandom); ar = 31'($urandom); ab = 31'($urandom);
               end
               1: ; // no motion
               2: begin
                  al = al + 31'($signed($urandom_range(0, 20)) - 10);
                  ar = ar + (al - prev_l);
               end
               default: begin
                  al = al + 31'($signed($urandom_range(0, 200)) - 100);
                  ar = ar + 31'($signed($urandom_range(0, 200)) - 100);
                  ab = ab + 31'($signed($urandom_range(0, 200)) - 100);
               end
            endcase
            send_sample(al, ar, ab);
         end
      end
   endtask

   initial begin
      regs = '{32'd393216, 32'd393216, 32'd262144, 32'd2287, 0, 0, 0};
      prev_l = '0; prev_r = '0; prev_b = '0;
      pose_x = 0; pose_y = 0; pose_head = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_wheel_base();
      test_random_runs();
      while (pose_q.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[tracking_wheel_odometry_unit.f]
rtl/core/twodo_pkg.sv
rtl/core/twodo_div.sv
rtl/core/twodo_cordic.sv
rtl/core/tracking_wheel_odometry_unit.sv
tb/tracking_wheel_odometry_unit_tb.sv
